@@ sv/kpc_pkg.sv @@
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared constants and the per-key record type of the key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

  // number of key records held in the record memory
  localparam int NUM_KEYS = 8;
  localparam int ADDR_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // field widths fixed by the sample and result formats
  localparam int KEY_W    = 3;
  localparam int STATUS_W = 16;
  localparam int COUNT_W  = 16;
  localparam int CFG_W    = 4;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_RELEASED = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_PRESSED  = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_HELD     = STATUS_W'(2);

  // active key count after reset
  localparam logic [CFG_W-1:0] ACTIVE_KEYS_RESET = CFG_W'(8);

  // one key record as stored in memory
  typedef struct packed {
    logic                is_pressed;
    logic                is_long;
    logic [STATUS_W-1:0] shown;
    logic [COUNT_W-1:0]  single_cnt;
    logic [COUNT_W-1:0]  long_cnt;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

@@ sv/kpc_ram.sv @@
// ----------------------------------------------------------------------------
// kpc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module kpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/key_press_classifier.sv @@
// The sample beat captures the sample and starts the record memory read;
// the lookup state then classifies the record and registers the result.
// A new sample is taken only after its lookup is done, since the record
// memory's read is followed by the write back of the updated record.
// The input side takes a new sample while a result still waits at the output.
// Reset (rst, synchronous) clears every key record at once through per-key
// valid bits and sets the active key count to 8.
// ----------------------------------------------------------------------------
// key_press_classifier
// Per-key press classifier: reads a key record, classifies single and long
// presses from the polled status, writes the record back and reports it.
// ----------------------------------------------------------------------------
module key_press_classifier (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kpc_pkg::CFG_W-1:0]     cfg_data,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kpc_pkg::KEY_W-1:0]     key_index,
  input  logic                          new_press,
  input  logic [kpc_pkg::STATUS_W-1:0]  raw_status,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          accepted,
  output logic [kpc_pkg::STATUS_W-1:0]  shown_status,
  output logic [kpc_pkg::COUNT_W-1:0]   single_count,
  output logic [kpc_pkg::COUNT_W-1:0]   long_count
);

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_t;

  state_t                         state;
  logic [kpc_pkg::CFG_W-1:0]      active_keys;
  logic [kpc_pkg::KEY_W-1:0]      key_q;
  logic                           press_q;
  logic [kpc_pkg::STATUS_W-1:0]   status_q;
  logic [kpc_pkg::NUM_KEYS-1:0]   rec_valid;

  logic [kpc_pkg::ADDR_W-1:0]     raddr;
  logic [kpc_pkg::ADDR_W-1:0]     addr_q;
  logic [kpc_pkg::REC_W-1:0]      rdata;
  kpc_pkg::rec_t                  rec_rd;
  kpc_pkg::rec_t                  rec_wr;
  logic                           ram_we;
  logic                           in_range;
  logic                           out_free;
  logic                           finish;

  // configuration register is writable outside reset
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_keys <= kpc_pkg::ACTIVE_KEYS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_keys <= cfg_data;
    end
  end

  // record memory
  assign addr_q = kpc_pkg::ADDR_W'(key_q);
  assign raddr  = (in_valid && in_ready) ? kpc_pkg::ADDR_W'(key_index) : addr_q;

  kpc_ram #(
    .WIDTH (kpc_pkg::REC_W),
    .DEPTH (kpc_pkg::NUM_KEYS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q),
    .wdata (rec_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // a record never written since reset reads as all zero
  assign rec_rd = rec_valid[addr_q] ? kpc_pkg::rec_t'(rdata) : '0;

  assign in_range = ({1'b0, key_q} < active_keys) && (32'(key_q) < kpc_pkg::NUM_KEYS);
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == S_LOOK) && out_free;
  assign ram_we   = finish && in_range;
  assign in_ready = (state == S_IDLE) && !rst;

  // press classification
  always_comb begin
    logic                         p;
    logic                         l;
    logic                         np;
    logic [kpc_pkg::STATUS_W-1:0] st;
    logic [kpc_pkg::COUNT_W-1:0]  sc;
    logic [kpc_pkg::COUNT_W-1:0]  lc;
    p  = rec_rd.is_pressed;
    l  = rec_rd.is_long;
    sc = rec_rd.single_cnt;
    lc = rec_rd.long_cnt;
    // released and pressed again between polls
    if (press_q && p && !l) begin
      sc = sc + kpc_pkg::COUNT_W'(1);
    end
    // a press begun after the status code was read still counts as new
    np = press_q || ((status_q != kpc_pkg::STATUS_RELEASED) && !p);
    if (np) begin
      p = 1'b1;
      l = 1'b0;
    end
    st = status_q;
    if ((status_q == kpc_pkg::STATUS_HELD) && !l) begin
      l  = 1'b1;
      lc = lc + kpc_pkg::COUNT_W'(1);
    end
    if (p && (status_q == kpc_pkg::STATUS_RELEASED)) begin
      if (!l) begin
        sc = sc + kpc_pkg::COUNT_W'(1);
      end
      p = 1'b0;
      if (np) begin
        st = kpc_pkg::STATUS_PRESSED;
      end
    end
    rec_wr.is_pressed = p;
    rec_wr.is_long    = l;
    rec_wr.shown      = st;
    rec_wr.single_cnt = sc;
    rec_wr.long_cnt   = lc;
  end

  // valid bits of the records
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= '0;
    end else if (ram_we) begin
      rec_valid[addr_q] <= 1'b1;
    end
  end

  // control state, captured sample and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    // sample capture
    if (in_valid && in_ready) begin
      key_q    <= key_index;
      press_q  <= new_press;
      status_q <= raw_status;
    end
    // result beat
    if (finish) begin
      accepted     <= in_range;
      shown_status <= in_range ? rec_wr.shown : '0;
      single_count <= in_range ? rec_wr.single_cnt : '0;
      long_count   <= in_range ? rec_wr.long_cnt : '0;
    end
  end

`ifndef NO_ASSERTIONS
  // an accepted sample is looked up in the next cycle
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_LOOK))
    else $error("sample beat not followed by record lookup");

  // the record memory is written only while finishing a lookup
  a_write_look: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_LOOK) && out_free))
    else $error("record write outside lookup");

  // a finished lookup always produces a result beat
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("lookup finished without result");

  // a rejected sample reports zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |->
      ((shown_status == '0) && (single_count == '0) && (long_count == '0)))
    else $error("rejected sample with nonzero fields");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key press classifier. A queue of samples feeds
// a handshaking driver; every accepted sample is run through a local copy of
// the per-key records to predict its report, and a monitor compares each
// report beat field by field. Both sides idle at random and the active key
// count is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic [kpc_pkg::KEY_W-1:0]    key;
    logic                         np;
    logic [kpc_pkg::STATUS_W-1:0] status;
  } sample_t;

  typedef struct packed {
    logic                         acc;
    logic [kpc_pkg::STATUS_W-1:0] shown;
    logic [kpc_pkg::COUNT_W-1:0]  singles;
    logic [kpc_pkg::COUNT_W-1:0]  longs;
  } report_t;

  logic                         clk;
  logic                         rst          = 1'b1;
  logic                         cfg_valid    = 1'b0;
  logic                         cfg_ready;
  logic [kpc_pkg::CFG_W-1:0]    cfg_data     = '0;
  logic                         in_valid     = 1'b0;
  logic                         in_ready;
  logic [kpc_pkg::KEY_W-1:0]    key_index    = '0;
  logic                         new_press    = 1'b0;
  logic [kpc_pkg::STATUS_W-1:0] raw_status   = '0;
  logic                         out_valid;
  logic                         out_ready    = 1'b0;
  logic                         accepted;
  logic [kpc_pkg::STATUS_W-1:0] shown_status;
  logic [kpc_pkg::COUNT_W-1:0]  single_count;
  logic [kpc_pkg::COUNT_W-1:0]  long_count;

  // predictor state: active key count and one record per key
  logic [kpc_pkg::CFG_W-1:0] active_keys = kpc_pkg::ACTIVE_KEYS_RESET;
  kpc_pkg::rec_t             key_rec[kpc_pkg::NUM_KEYS];

  sample_t     pending_samples[$];
  report_t     expected_reports[$];
  int unsigned outstanding = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  int unsigned gap_left    = 0;
  int unsigned in_steady   = 0;
  int unsigned stall_left  = 0;
  int unsigned out_steady  = 0;
  sample_t     next_sample;
  report_t     got;
  report_t     want;

  key_press_classifier u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .key_index    (key_index),
    .new_press    (new_press),
    .raw_status   (raw_status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .shown_status (shown_status),
    .single_count (single_count),
    .long_count   (long_count)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int unsigned pick_gap(inout int unsigned steady);
    int unsigned r;
    if (steady != 0) begin
      steady--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // update the key record for one accepted sample and queue its report
  function automatic void classify_sample(sample_t s);
    kpc_pkg::rec_t r;
    report_t       res;
    logic          np;
    res = '0;
    if (s.key < active_keys && s.key < kpc_pkg::NUM_KEYS) begin
      r  = key_rec[s.key];
      np = s.np;
      // released and pressed again between two polls
      if (np && r.is_pressed && !r.is_long)
        r.single_cnt = r.single_cnt + kpc_pkg::COUNT_W'(1);
      // a press that began after the code was read is still new
      np = np || (s.status != kpc_pkg::STATUS_RELEASED && !r.is_pressed);
      if (np) begin
        r.is_pressed = 1'b1;
        r.is_long    = 1'b0;
      end
      r.shown = s.status;
      if (s.status == kpc_pkg::STATUS_HELD && !r.is_long) begin
        r.is_long  = 1'b1;
        r.long_cnt = r.long_cnt + kpc_pkg::COUNT_W'(1);
      end
      if (r.is_pressed && s.status == kpc_pkg::STATUS_RELEASED) begin
        if (!r.is_long) r.single_cnt = r.single_cnt + kpc_pkg::COUNT_W'(1);
        r.is_pressed = 1'b0;
        if (np) r.shown = kpc_pkg::STATUS_PRESSED;
      end
      key_rec[s.key] = r;
      res = '{1'b1, r.shown, r.single_cnt, r.long_cnt};
    end
    expected_reports.insert(expected_reports.size(), res);
  endfunction

  task automatic report_mismatch(string what, report_t exp_r, report_t act_r);
    error_count++;
    if (error_count <= 10)
      $display("[%0t] %s: exp acc=%0b st=%h sc=%h lc=%h  got acc=%0b st=%h sc=%h lc=%h",
               $realtime, what, exp_r.acc, exp_r.shown, exp_r.singles, exp_r.longs,
               act_r.acc, act_r.shown, act_r.singles, act_r.longs);
  endtask

  task automatic queue_sample(input logic [kpc_pkg::KEY_W-1:0] k, input logic np,
                              input logic [kpc_pkg::STATUS_W-1:0] status);
    pending_samples.insert(pending_samples.size(), sample_t'{k, np, status});
    outstanding++;
  endtask

  // a press of one key: start, some polls while down, then release
  task automatic queue_press_sequence();
    int unsigned hi;
    int unsigned k;
    int unsigned len;
    int unsigned r;
    hi = (active_keys == 0 || active_keys > kpc_pkg::NUM_KEYS) ?
         kpc_pkg::NUM_KEYS - 1 : int'(active_keys) - 1;
    k  = $urandom_range(0, hi);
    r  = $urandom_range(0, 9);
    queue_sample(kpc_pkg::KEY_W'(k), 1'($urandom_range(0, 1)),
                 (r < 2) ? kpc_pkg::STATUS_RELEASED :
                 (r < 4) ? kpc_pkg::STATUS_HELD : kpc_pkg::STATUS_PRESSED);
    len = $urandom_range(0, 4);
    for (int i = 0; i < len; i++)
      queue_sample(kpc_pkg::KEY_W'(k), $urandom_range(0, 5) == 0,
                   $urandom_range(0, 1) ? kpc_pkg::STATUS_HELD : kpc_pkg::STATUS_PRESSED);
    queue_sample(kpc_pkg::KEY_W'(k), 1'b0, kpc_pkg::STATUS_RELEASED);
  endtask

  // random filler: sequences mostly, raw noise and stray indices otherwise
  task automatic queue_random_phase(int unsigned n);
    int unsigned stop_at;
    stop_at = outstanding + n;
    while (outstanding < stop_at) begin
      if ($urandom_range(0, 9) < 7)
        queue_press_sequence();
      else
        queue_sample(kpc_pkg::KEY_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     kpc_pkg::STATUS_W'($urandom_range(0, 65535)));
    end
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_active_keys(input logic [kpc_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    active_keys = value;
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        classify_sample(sample_t'({key_index, new_press, raw_status}));
        gap_left = pick_gap(in_steady);
      end
      if (!in_valid || in_ready) begin
        if (gap_left == 0 && pending_samples.size() != 0) begin
          next_sample = pending_samples.pop_front();
          in_valid   <= 1'b1;
          key_index  <= next_sample.key;
          new_press  <= next_sample.np;
          raw_status <= next_sample.status;
        end else begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // report monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{accepted, shown_status, single_count, long_count};
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected report", '0, got);
        end else begin
          want = expected_reports.pop_front();
          if (got.acc !== want.acc || got.shown !== want.shown ||
              got.singles !== want.singles || got.longs !== want.longs)
            report_mismatch("report mismatch", want, got);
        end
        if (outstanding != 0) outstanding--;
        stall_left = pick_gap(out_steady);
      end else if (stall_left == 0 && $urandom_range(0, 15) == 0) begin
        stall_left = pick_gap(out_steady);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("key_press_classifier verification failed");
      $finish;
    end
  end

  initial begin
    logic [kpc_pkg::CFG_W-1:0] cfg_plan[$];
    for (int i = 0; i < kpc_pkg::NUM_KEYS; i++) key_rec[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: basic press, release, hold and the odd corners, 8 keys active
    queue_sample(3'd0, 1'b0, kpc_pkg::STATUS_RELEASED);
    queue_sample(3'd0, 1'b1, kpc_pkg::STATUS_PRESSED);
    queue_sample(3'd0, 1'b0, kpc_pkg::STATUS_PRESSED);
    queue_sample(3'd0, 1'b0, kpc_pkg::STATUS_RELEASED);
    queue_sample(3'd0, 1'b1, kpc_pkg::STATUS_RELEASED);   // press already released
    queue_sample(3'd0, 1'b1, kpc_pkg::STATUS_PRESSED);
    queue_sample(3'd0, 1'b1, kpc_pkg::STATUS_PRESSED);    // press-release-press
    queue_sample(3'd0, 1'b0, kpc_pkg::STATUS_HELD);
    queue_sample(3'd0, 1'b0, kpc_pkg::STATUS_HELD);
    queue_sample(3'd0, 1'b0, kpc_pkg::STATUS_RELEASED);   // release after long press
    queue_sample(3'd1, 1'b0, kpc_pkg::STATUS_PRESSED);    // press seen without the code bit
    queue_sample(3'd1, 1'b1, kpc_pkg::STATUS_HELD);
    queue_sample(3'd2, 1'b0, 16'hffff);                   // unknown status words
    queue_sample(3'd2, 1'b1, 16'h8000);
    queue_sample(3'd2, 1'b0, 16'h0003);
    queue_sample(3'd2, 1'b0, kpc_pkg::STATUS_RELEASED);
    queue_sample(3'd7, 1'b1, kpc_pkg::STATUS_HELD);
    queue_sample(3'd7, 1'b1, kpc_pkg::STATUS_HELD);
    queue_sample(3'd7, 1'b1, kpc_pkg::STATUS_RELEASED);
    queue_sample(3'd7, 1'b0, kpc_pkg::STATUS_RELEASED);
    wait_drained();

    cfg_plan = '{4'd15, 4'd0, 4'd1, 4'd5, 4'd8};
    repeat (3) cfg_plan.insert(cfg_plan.size(), kpc_pkg::CFG_W'($urandom_range(1, 15)));
    foreach (cfg_plan[i]) begin
      write_active_keys(cfg_plan[i]);
      // boundary keys that fall out of range for small counts
      if (active_keys < kpc_pkg::NUM_KEYS)
        queue_sample(kpc_pkg::KEY_W'(active_keys), 1'b1, kpc_pkg::STATUS_PRESSED);
      queue_sample(3'd7, 1'b1, 16'hffff);
      queue_random_phase(active_keys == 0 ? 15 : 110);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("key_press_classifier verification clean");
    else
      $display("key_press_classifier verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
sv/kpc_pkg.sv
sv/kpc_ram.sv
sv/key_press_classifier.sv
sim/tb_top.sv
